// ===== hdl/adsc_pkg.sv =====
// Shared types and constants of the adaptive delay step controller.
package adsc_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [2:0] RegBusyLow  = 3'd0;
  localparam logic [2:0] RegBusyHigh = 3'd1;
  localparam logic [2:0] RegUpStep   = 3'd2;
  localparam logic [2:0] RegDownStep = 3'd3;
  localparam logic [2:0] RegLimit    = 3'd4;
  localparam logic [2:0] RegHoldDec  = 3'd5;
  localparam logic [2:0] RegHoldInc  = 3'd6;

  localparam logic [31:0] BusyLowReset  = 32'd30000;
  localparam logic [31:0] BusyHighReset = 32'd50000;
  localparam logic [15:0] UpStepReset   = 16'd50;
  localparam logic [15:0] DownStepReset = 16'd20;
  localparam logic [15:0] LimitReset    = 16'd1000;
  localparam logic [15:0] HoldDecReset  = 16'd2000;
  localparam logic [15:0] HoldIncReset  = 16'd1000;

  typedef struct packed {
    logic [31:0] busy_low;
    logic [31:0] busy_high;
    logic [15:0] up_step;
    logic [15:0] down_step;
    logic [15:0] delay_limit;
    logic [15:0] hold_dec;
    logic [15:0] hold_inc;
  } cfg_t;

  typedef struct packed {
    logic [15:0] delay;
    logic        holding;
  } step_res_t;

endpackage

// ===== hdl/adsc_core.sv =====
// Delay and hold state with the per-transaction step update.
module adsc_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_en_i,
  input  logic [31:0]             busy_time_i,
  input  logic [31:0]             now_ms_i,
  input  adsc_pkg::cfg_t          cfg_i,
  output adsc_pkg::step_res_t     res_o
);

  logic [15:0] delay_q, delay_d;
  logic        hold_active_q, hold_active_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic [15:0] hold_len_q, hold_len_d;

  logic [31:0] elapsed;
  logic        held;
  logic        dec_take, inc_take;
  logic        dec_under, inc_over;
  logic [16:0] sum;

  assign elapsed   = now_ms_i - hold_start_q;
  assign held      = hold_active_q && (elapsed < {16'b0, hold_len_q});
  assign dec_take  = (busy_time_i < cfg_i.busy_low) && (delay_q != 16'd0);
  assign inc_take  = !dec_take && (busy_time_i >= cfg_i.busy_high)
                     && (delay_q != cfg_i.delay_limit);
  assign dec_under = cfg_i.down_step > delay_q;
  assign sum       = {1'b0, delay_q} + {1'b0, cfg_i.up_step};
  assign inc_over  = sum > {1'b0, cfg_i.delay_limit};

  always_comb begin
    delay_d       = delay_q;
    hold_active_d = hold_active_q;
    hold_start_d  = hold_start_q;
    hold_len_d    = hold_len_q;
    if (!held) begin
      // an expired hold is dropped; a non-clamped step arms a new one
      hold_active_d = 1'b0;
      if (dec_take) begin
        if (dec_under) begin
          delay_d = '0;
        end else begin
          delay_d       = delay_q - cfg_i.down_step;
          hold_active_d = 1'b1;
          hold_start_d  = now_ms_i;
          hold_len_d    = cfg_i.hold_dec;
        end
      end else if (inc_take) begin
        if (inc_over) begin
          delay_d = cfg_i.delay_limit;
        end else begin
          delay_d       = sum[15:0];
          hold_active_d = 1'b1;
          hold_start_d  = now_ms_i;
          hold_len_d    = cfg_i.hold_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q       <= '0;
      hold_active_q <= 1'b0;
      hold_start_q  <= '0;
      hold_len_q    <= '0;
    end else if (step_en_i) begin
      delay_q       <= delay_d;
      hold_active_q <= hold_active_d;
      hold_start_q  <= hold_start_d;
      hold_len_q    <= hold_len_d;
    end
  end

  assign res_o.delay   = delay_d;
  assign res_o.holding = held;

`ifndef ASSERT_OFF
  a_held_keeps_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && held |=> delay_q == $past(delay_q))
    else $error("delay changed during an active hold");

  a_idle_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(delay_q) && $stable(hold_active_q) && $stable(hold_start_q))
    else $error("state changed without a transaction");

  a_hold_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && !held && hold_active_d |=> hold_start_q == $past(now_ms_i))
    else $error("new hold did not capture the transaction timestamp");
`endif

endmodule

// ===== hdl/adaptive_delay_step_controller.sv =====
// Adaptive delay step controller: input register, step update, result register.
//
// Input channel (in_valid_i / in_stall_o) carries busy_time_i and now_ms_i for
// one request; the output channel (out_valid_o / out_stall_i) returns the
// delay to apply (delay_ms_o) and whether an active hold kept it (holding_o).
// A transaction is taken at a rising edge with valid high and stall low.
// An accepted request is registered in the input register, then its result in the result register.
// One transaction per cycle is sustained while out_stall_i is low; the delay/hold update is combinational.
// When the receiver stalls, the result register holds its transaction and the
// input register still takes one more; only then is in_stall_o raised.
// Reset clears the delay, the hold timer and the valid flags of both pipeline stages, and loads
// the threshold, step, limit and hold registers with their defaults.
// The APB port writes registers at byte address 4*i and reads them back;
// writes are expected only while no transaction is in flight.
module adaptive_delay_step_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    busy_time_i,
  input  logic [31:0]                    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    delay_ms_o,
  output logic                           holding_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [adsc_pkg::AddrWidth-1:0] paddr,
  input  logic [adsc_pkg::DataWidth-1:0] pwdata,
  output logic [adsc_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  adsc_pkg::cfg_t      cfg_q;
  adsc_pkg::step_res_t res;

  logic        s1_valid_q;
  logic [31:0] s1_busy_q, s1_now_q;
  logic        out_valid_q;
  logic [15:0] delay_q;
  logic        holding_q;
  logic        out_free, s1_move, in_take, cfg_wr;
  logic [2:0]  reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[adsc_pkg::AddrWidth-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.busy_low    <= adsc_pkg::BusyLowReset;
      cfg_q.busy_high   <= adsc_pkg::BusyHighReset;
      cfg_q.up_step     <= adsc_pkg::UpStepReset;
      cfg_q.down_step   <= adsc_pkg::DownStepReset;
      cfg_q.delay_limit <= adsc_pkg::LimitReset;
      cfg_q.hold_dec    <= adsc_pkg::HoldDecReset;
      cfg_q.hold_inc    <= adsc_pkg::HoldIncReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        adsc_pkg::RegBusyLow:  cfg_q.busy_low    <= pwdata;
        adsc_pkg::RegBusyHigh: cfg_q.busy_high   <= pwdata;
        adsc_pkg::RegUpStep:   cfg_q.up_step     <= pwdata[15:0];
        adsc_pkg::RegDownStep: cfg_q.down_step   <= pwdata[15:0];
        adsc_pkg::RegLimit:    cfg_q.delay_limit <= pwdata[15:0];
        adsc_pkg::RegHoldDec:  cfg_q.hold_dec    <= pwdata[15:0];
        adsc_pkg::RegHoldInc:  cfg_q.hold_inc    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      adsc_pkg::RegBusyLow:  prdata = cfg_q.busy_low;
      adsc_pkg::RegBusyHigh: prdata = cfg_q.busy_high;
      adsc_pkg::RegUpStep:   prdata = {16'b0, cfg_q.up_step};
      adsc_pkg::RegDownStep: prdata = {16'b0, cfg_q.down_step};
      adsc_pkg::RegLimit:    prdata = {16'b0, cfg_q.delay_limit};
      adsc_pkg::RegHoldDec:  prdata = {16'b0, cfg_q.hold_dec};
      adsc_pkg::RegHoldInc:  prdata = {16'b0, cfg_q.hold_inc};
      default:               prdata = '0;
    endcase
  end

  // Pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_busy_q <= busy_time_i;
      s1_now_q  <= now_ms_i;
    end
    if (s1_move) begin
      delay_q   <= res.delay;
      holding_q <= res.holding;
    end
  end

  adsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (s1_move),
    .busy_time_i (s1_busy_q),
    .now_ms_i    (s1_now_q),
    .cfg_i       (cfg_q),
    .res_o       (res)
  );

  assign out_valid_o = out_valid_q;
  assign delay_ms_o  = delay_q;
  assign holding_o   = holding_q;

`ifndef ASSERT_OFF
  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_now_q) && $stable(s1_busy_q))
    else $error("input register lost a waiting transaction");

  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(delay_q))
    else $error("stalled result was overwritten");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while a stage was free");
`endif

endmodule
